[hdl/daty_pkg.sv]
// Shared types, constants and helper functions for the desired-attitude block.
`timescale 1ns / 1ps

package daty_pkg;

   // Default parameter values.
   localparam int FRAC_BITS_DEF = 14;
   localparam int ROT_ITER_DEF  = 16;

   // Angle and vector formats.
   localparam int ANG_FRAC = 30;

   // Angle constants in Q30 radians.
   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

   // Reciprocal of the limit gain of the rotation iterations in Q30.
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   // One reduced item handed from the front to the back.
   typedef struct packed {
      logic signed [31:0] angle;
      logic               neg;
      logic signed [15:0] tx;
      logic signed [15:0] ty;
      logic signed [15:0] tz;
   } daty_item_type;

   // One finished matrix.
   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic               degenerate;
   } daty_result_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      BK_IDLE,
      BK_CORDIC,
      BK_CROSS,
      BK_DIFF,
      BK_MAX,
      BK_NORM,
      BK_SQUARE,
      BK_SUM,
      BK_SQRT,
      BK_DLOAD,
      BK_DIV,
      BK_XPROD,
      BK_FINISH
   } daty_state_type;

   // Arctangent of 2^-i in Q30.
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h3243F6A8;
         5'd1:    v = 32'h1DAC6705;
         5'd2:    v = 32'h0FADBAFC;
         5'd3:    v = 32'h07F56EA6;
         5'd4:    v = 32'h03FEAB76;
         5'd5:    v = 32'h01FFD55B;
         5'd6:    v = 32'h00FFFAAA;
         5'd7:    v = 32'h007FFF55;
         5'd8:    v = 32'h003FFFEA;
         5'd9:    v = 32'h001FFFFD;
         5'd10:   v = 32'h000FFFFF;
         5'd11:   v = 32'h0007FFFF;
         5'd12:   v = 32'h0003FFFF;
         5'd13:   v = 32'h0001FFFF;
         5'd14:   v = 32'h0000FFFF;
         5'd15:   v = 32'h00007FFF;
         5'd16:   v = 32'h00003FFF;
         5'd17:   v = 32'h00001FFF;
         5'd18:   v = 32'h00000FFF;
         5'd19:   v = 32'h000007FF;
         5'd20:   v = 32'h000003FF;
         5'd21:   v = 32'h000001FF;
         5'd22:   v = 32'h000000FF;
         5'd23:   v = 32'h0000007F;
         5'd24:   v = 32'h0000003F;
         5'd25:   v = 32'h0000001F;
         5'd26:   v = 32'h0000000F;
         5'd27:   v = 32'h00000008;
         5'd28:   v = 32'h00000004;
         5'd29:   v = 32'h00000002;
         5'd30:   v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // Saturate a wide signed value to 16 bits.
   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -64'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

[hdl/daty_front.sv]
// Front end: accepts items, reduces the yaw angle and folds it into the right half plane.
`timescale 1ns / 1ps

module daty_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_yaw_angle,
   input  logic signed [15:0]     req_thrust_dir_x,
   input  logic signed [15:0]     req_thrust_dir_y,
   input  logic signed [15:0]     req_thrust_dir_z,
   output logic                   push_valid,
   input  logic                   push_ready,
   output daty_pkg::daty_item_type push_item
);
   import daty_pkg::*;

   logic               valid_ff, valid_in;
   logic signed [32:0] angle_ff;
   logic signed [15:0] tx_ff, ty_ff, tz_ff;
   logic signed [35:0] yaw_w, red_w, ang_w, fold_w;
   logic               neg_w;

   // Widen Q3.12 to Q30 and bring the angle into [-pi, pi].
   always_comb begin
      yaw_w = {{2{req_yaw_angle[15]}}, req_yaw_angle, 18'b0};
      if (yaw_w > PI_Q30) begin
         red_w = yaw_w - TWO_PI_Q30;
      end else if (yaw_w < -PI_Q30) begin
         red_w = yaw_w + TWO_PI_Q30;
      end else begin
         red_w = yaw_w;
      end
   end

   assign req_ready = !valid_ff || push_ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         angle_ff <= red_w[32:0];
         tx_ff    <= req_thrust_dir_x;
         ty_ff    <= req_thrust_dir_y;
         tz_ff    <= req_thrust_dir_z;
      end
   end

   // Fold angles beyond a quarter turn; the back end negates sine and cosine.
   always_comb begin
      ang_w = 36'(angle_ff);
      neg_w = 1'b0;
      if (ang_w > HALF_PI_Q30) begin
         fold_w = ang_w - PI_Q30;
         neg_w  = 1'b1;
      end else if (ang_w < -HALF_PI_Q30) begin
         fold_w = ang_w + PI_Q30;
         neg_w  = 1'b1;
      end else begin
         fold_w = ang_w;
      end
   end

   assign push_valid      = valid_ff;
   assign push_item.angle = fold_w[31:0];
   assign push_item.neg   = neg_w;
   assign push_item.tx    = tx_ff;
   assign push_item.ty    = ty_ff;
   assign push_item.tz    = tz_ff;

endmodule

[hdl/daty_queue.sv]
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module daty_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  daty_pkg::daty_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output daty_pkg::daty_item_type pop_item
);
   import daty_pkg::*;

   daty_item_type ents_ff [2];
   logic          wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_item   = ents_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wptr_in = do_push ? !wptr_ff : wptr_ff;
      rptr_in = do_pop ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ents_ff[wptr_ff] <= push_item;
      end
   end

endmodule

[hdl/daty_back.sv]
// Back end: sine and cosine, cross products, normalization and matrix assembly.
`timescale 1ns / 1ps

module daty_back #(
   parameter int FRAC_BITS           = daty_pkg::FRAC_BITS_DEF,
   parameter int ROTATION_ITERATIONS = daty_pkg::ROT_ITER_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  daty_pkg::daty_item_type   pop_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output daty_pkg::daty_result_type out_result
);
   import daty_pkg::*;

   localparam int NITER = (ROTATION_ITERATIONS > 32) ? 32 : ROTATION_ITERATIONS;
   localparam int YSH   = ANG_FRAC - FRAC_BITS;
   localparam logic signed [63:0] YHALF = (64'sd1 <<< YSH) >>> 1;
   localparam logic signed [63:0] XHALF = 64'sd1 <<< (ANG_FRAC - 1);

   daty_state_type     state_ff, state_in;
   daty_item_type      item_ff;
   logic signed [15:0] tx_w, ty_w, tz_w;

   // Rotation registers.
   logic signed [33:0] cx_ff, cy_ff, ca_ff, at_w, cc_w, cs_w;
   logic [5:0]         iter_ff;

   // Cross product, normalization and square root registers.
   logic signed [49:0] p_ff [4];
   logic signed [50:0] u_ff [3];
   logic [50:0]        umag_w [3];
   logic [31:0]        mag_w [3];
   logic [50:0]        m_ff, m_w;
   logic               degen_ff;
   logic [63:0]        sq_ff [3];
   logic [63:0]        rad_ff;
   logic [33:0]        rem_ff;
   logic [31:0]        root_ff;
   logic [35:0]        st_w, trial_w;
   logic [5:0]         cnt_ff;

   // Divider registers.
   logic [1:0]         k_ff;
   logic [31:0]        drem_ff;
   logic [30:0]        dlow_ff, quo_ff, qfin_w;
   logic [61:0]        num_w;
   logic [32:0]        dt_w;
   logic               qbit_w;
   logic signed [31:0] y_ff [3];
   logic signed [31:0] ynew_w;
   logic signed [47:0] xp_ff [6];

   // Output register and control strobes.
   logic               out_valid_ff;
   daty_result_type    res_ff, res_w;
   logic               load_out, norm_done, sqrt_last, div_last, cordic_last;
   logic signed [63:0] d_w [3];

   assign tx_w = item_ff.tx;
   assign ty_w = item_ff.ty;
   assign tz_w = item_ff.tz;

   // Magnitudes of the cross product components.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         umag_w[k] = u_ff[k][50] ? 51'(-u_ff[k]) : 51'(u_ff[k]);
         mag_w[k]  = umag_w[k][31:0];
      end
      m_w = umag_w[0];
      if (umag_w[1] > m_w) begin
         m_w = umag_w[1];
      end
      if (umag_w[2] > m_w) begin
         m_w = umag_w[2];
      end
   end

   // Step conditions.
   assign cordic_last = (iter_ff == 6'(NITER - 1));
   assign norm_done   = (m_ff < (51'd1 << 31)) && (m_ff >= (51'd1 << 30));
   assign sqrt_last   = (cnt_ff == 6'd31);
   assign div_last    = (cnt_ff == 6'd30);

   // Signs of sine and cosine follow the quarter-turn fold.
   assign cc_w = item_ff.neg ? -cx_ff : cx_ff;
   assign cs_w = item_ff.neg ? -cy_ff : cy_ff;
   assign at_w = {2'b00, atan_q30(iter_ff[4:0])};

   // One square root step: two radicand bits per cycle.
   assign st_w    = {rem_ff, rad_ff[63:62]};
   assign trial_w = {2'b00, root_ff, 2'b01};

   // One divider step: one quotient bit per cycle.
   assign num_w  = {mag_w[k_ff], 30'b0} + 62'(root_ff >> 1);
   assign dt_w   = {drem_ff, dlow_ff[30]};
   assign qbit_w = (dt_w >= {1'b0, root_ff});
   assign qfin_w = {quo_ff[29:0], qbit_w};
   assign ynew_w = u_ff[k_ff][50] ? -$signed({1'b0, qfin_w}) : $signed({1'b0, qfin_w});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (pop_valid) state_in = BK_CORDIC;
         BK_CORDIC: if (cordic_last) state_in = BK_CROSS;
         BK_CROSS:  state_in = BK_DIFF;
         BK_DIFF:   state_in = BK_MAX;
         BK_MAX:    state_in = BK_NORM;
         BK_NORM: begin
            if (m_ff == 51'd0) begin
               state_in = BK_FINISH;
            end else if (norm_done) begin
               state_in = BK_SQUARE;
            end
         end
         BK_SQUARE: state_in = BK_SUM;
         BK_SUM:    state_in = BK_SQRT;
         BK_SQRT:   if (sqrt_last) state_in = BK_DLOAD;
         BK_DLOAD:  state_in = BK_DIV;
         BK_DIV: begin
            if (div_last) begin
               state_in = (k_ff == 2'd2) ? BK_XPROD : BK_DLOAD;
            end
         end
         BK_XPROD:  state_in = BK_FINISH;
         BK_FINISH: if (!out_valid_ff || out_ready) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      pop_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         BK_IDLE:   pop_ready = 1'b1;
         BK_FINISH: load_out = !out_valid_ff || out_ready;
         default: begin
            pop_ready = 1'b0;
            load_out  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            item_ff  <= pop_item;
            cx_ff    <= CORDIC_GAIN_Q30;
            cy_ff    <= 34'sd0;
            ca_ff    <= 34'(pop_item.angle);
            iter_ff  <= 6'd0;
            degen_ff <= 1'b0;
         end
         BK_CORDIC: begin
            if (!ca_ff[33]) begin
               cx_ff <= cx_ff - (cy_ff >>> iter_ff[4:0]);
               cy_ff <= cy_ff + (cx_ff >>> iter_ff[4:0]);
               ca_ff <= ca_ff - at_w;
            end else begin
               cx_ff <= cx_ff + (cy_ff >>> iter_ff[4:0]);
               cy_ff <= cy_ff - (cx_ff >>> iter_ff[4:0]);
               ca_ff <= ca_ff + at_w;
            end
            iter_ff <= iter_ff + 6'd1;
         end
         BK_CROSS: begin
            p_ff[0] <= tz_w * cs_w;
            p_ff[1] <= tz_w * cc_w;
            p_ff[2] <= tx_w * cs_w;
            p_ff[3] <= ty_w * cc_w;
         end
         BK_DIFF: begin
            u_ff[0] <= -51'(p_ff[0]);
            u_ff[1] <= 51'(p_ff[1]);
            u_ff[2] <= 51'(p_ff[2]) - 51'(p_ff[3]);
         end
         BK_MAX: begin
            m_ff <= m_w;
         end
         BK_NORM: begin
            if (m_ff == 51'd0) begin
               degen_ff <= 1'b1;
            end else if (m_ff >= (51'd1 << 31)) begin
               m_ff <= m_ff >> 1;
               for (int k = 0; k < 3; k++) u_ff[k] <= u_ff[k] >>> 1;
            end else if (m_ff < (51'd1 << 30)) begin
               m_ff <= m_ff << 1;
               for (int k = 0; k < 3; k++) u_ff[k] <= u_ff[k] <<< 1;
            end
         end
         BK_SQUARE: begin
            for (int k = 0; k < 3; k++) sq_ff[k] <= mag_w[k] * mag_w[k];
         end
         BK_SUM: begin
            rad_ff  <= sq_ff[0] + sq_ff[1] + sq_ff[2];
            rem_ff  <= 34'd0;
            root_ff <= 32'd0;
            cnt_ff  <= 6'd0;
         end
         BK_SQRT: begin
            if (st_w >= trial_w) begin
               rem_ff  <= 34'(st_w - trial_w);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= st_w[33:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
            rad_ff <= rad_ff << 2;
            cnt_ff <= cnt_ff + 6'd1;
            k_ff   <= 2'd0;
         end
         BK_DLOAD: begin
            drem_ff <= {1'b0, num_w[61:31]};
            dlow_ff <= num_w[30:0];
            quo_ff  <= 31'd0;
            cnt_ff  <= 6'd0;
         end
         BK_DIV: begin
            drem_ff <= qbit_w ? 32'(dt_w - {1'b0, root_ff}) : dt_w[31:0];
            dlow_ff <= dlow_ff << 1;
            quo_ff  <= qfin_w;
            cnt_ff  <= cnt_ff + 6'd1;
            if (div_last) begin
               y_ff[k_ff] <= ynew_w;
               k_ff       <= k_ff + 2'd1;
            end
         end
         BK_XPROD: begin
            xp_ff[0] <= y_ff[1] * tz_w;
            xp_ff[1] <= y_ff[2] * ty_w;
            xp_ff[2] <= y_ff[2] * tx_w;
            xp_ff[3] <= y_ff[0] * tz_w;
            xp_ff[4] <= y_ff[0] * ty_w;
            xp_ff[5] <= y_ff[1] * tx_w;
         end
         default: begin
         end
      endcase
   end

   // Assemble the matrix: round x and y columns (zero for a degenerate item), echo the thrust column.
   always_comb begin
      d_w[0] = 64'(xp_ff[0]) - 64'(xp_ff[1]);
      d_w[1] = 64'(xp_ff[2]) - 64'(xp_ff[3]);
      d_w[2] = 64'(xp_ff[4]) - 64'(xp_ff[5]);
      res_w.m02 = tx_w;
      res_w.m12 = ty_w;
      res_w.m22 = tz_w;
      res_w.degenerate = degen_ff;
      if (degen_ff) begin
         res_w.m00 = 16'sd0;
         res_w.m10 = 16'sd0;
         res_w.m20 = 16'sd0;
         res_w.m01 = 16'sd0;
         res_w.m11 = 16'sd0;
         res_w.m21 = 16'sd0;
      end else begin
         res_w.m00 = sat16((d_w[0] + XHALF) >>> ANG_FRAC);
         res_w.m10 = sat16((d_w[1] + XHALF) >>> ANG_FRAC);
         res_w.m20 = sat16((d_w[2] + XHALF) >>> ANG_FRAC);
         res_w.m01 = sat16((64'(y_ff[0]) + YHALF) >>> YSH);
         res_w.m11 = sat16((64'(y_ff[1]) + YHALF) >>> YSH);
         res_w.m21 = sat16((64'(y_ff[2]) + YHALF) >>> YSH);
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         res_ff <= res_w;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = res_ff;

endmodule

[hdl/desired_attitude_from_thrust_yaw.sv]
// Top level of the desired-attitude-from-thrust-and-yaw block.
`timescale 1ns / 1ps

// Builds the rotation matrix whose columns are x, y = normalize(z cross h) and the thrust
// axis z, with h = (cos yaw, sin yaw, 0). Yaw is Q3.12 radians, vectors are Q1.14 by
// default, and all outputs saturate to 16 bits. When z cross h is exactly zero the
// degenerate flag is set and the x and y columns read zero. The front end takes a new
// item every cycle while the two-entry queue behind it has room; the back end then works
// one item at a time, normalizing by single-bit shifts. A degenerate item skips the
// square root and the divisions. The shared iterative units of the back end are the
// rotation loop, the 32-step square root and three 31-step divisions, each resolving
// one step per cycle. A finished matrix waits in an output register, so the back end
// starts the next item while the result is held; it stalls only when a second matrix
// is ready before the first leaves.

module desired_attitude_from_thrust_yaw #(
   parameter int FRAC_BITS           = daty_pkg::FRAC_BITS_DEF,
   parameter int ROTATION_ITERATIONS = daty_pkg::ROT_ITER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_thrust_dir_x,
   input  logic signed [15:0] req_thrust_dir_y,
   input  logic signed [15:0] req_thrust_dir_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m02,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m12,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m22,
   output logic               rsp_degenerate
);
   import daty_pkg::*;

   logic            push_valid, push_ready, pop_valid, pop_ready;
   daty_item_type   push_item, pop_item;
   daty_result_type result;

   // Accept and reduce the angle.
   daty_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_yaw_angle    (req_yaw_angle),
      .req_thrust_dir_x (req_thrust_dir_x),
      .req_thrust_dir_y (req_thrust_dir_y),
      .req_thrust_dir_z (req_thrust_dir_z),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_item        (push_item)
   );

   // Queue between front and back.
   daty_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Compute the matrix.
   daty_back #(
      .FRAC_BITS           (FRAC_BITS),
      .ROTATION_ITERATIONS (ROTATION_ITERATIONS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_m00        = result.m00;
   assign rsp_m01        = result.m01;
   assign rsp_m02        = result.m02;
   assign rsp_m10        = result.m10;
   assign rsp_m11        = result.m11;
   assign rsp_m12        = result.m12;
   assign rsp_m20        = result.m20;
   assign rsp_m21        = result.m21;
   assign rsp_m22        = result.m22;
   assign rsp_degenerate = result.degenerate;

endmodule
